>>> design/rcfb_pkg.sv
// Package for the RGB color fade blender: widths, config register codes
// and the pipeline payload structs. No dependencies.
`timescale 1ns / 1ps
package rcfb_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned NumChan     = 3;
  localparam int unsigned ColorW      = ChanW * NumChan;
  localparam int unsigned StepW       = 16;
  localparam int unsigned NumW        = ChanW + StepW;     // numerator width
  localparam int unsigned QBitsPerStg = 2;                 // quotient bits per stage
  localparam int unsigned DivStages   = ChanW / QBitsPerStg;

  // config register indexes
  localparam logic REG_TARGET_COLOR = 1'b0;
  localparam logic REG_STEP_COUNT   = 1'b1;

  // front stage: operands before the multiplies
  typedef struct packed {
    logic [ColorW-1:0] src;
    logic [ColorW-1:0] tgt;
    logic [StepW-1:0]  k;
    logic [StepW-1:0]  nk;      // count - step
    logic [StepW-1:0]  n;
    logic              bypass;  // count zero or step at/past count
  } front_t;

  // division pipeline word: per channel {partial remainder, numerator/quotient bits}
  typedef struct packed {
    logic [NumChan-1:0][NumW-1:0] acc;
    logic [StepW-1:0]             divisor;
    logic [ColorW-1:0]            tgt;
    logic                         bypass;
  } pipe_t;

endpackage

>>> design/rcfb_mix.sv
// Two front pipeline stages: operand prep (count - step, bypass flag),
// then per-channel products and numerator sum. Depends on rcfb_pkg.
`timescale 1ns / 1ps
module rcfb_mix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [rcfb_pkg::ColorW-1:0]  src_i,
  input  logic [rcfb_pkg::StepW-1:0]   step_i,
  input  logic [rcfb_pkg::ColorW-1:0]  tgt_i,
  input  logic [rcfb_pkg::StepW-1:0]   count_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output rcfb_pkg::pipe_t              data_o
);

  logic             a_valid_q;
  logic             a_ready;
  rcfb_pkg::front_t a_d, a_q;
  logic             b_valid_q;
  rcfb_pkg::pipe_t  b_d, b_q;

  // stage A
  assign a_ready = !a_valid_q || !b_valid_q || ready_i;
  assign ready_o = a_ready;

  always_comb begin
    a_d.src    = src_i;
    a_d.tgt    = tgt_i;
    a_d.k      = step_i;
    a_d.n      = count_i;
    a_d.nk     = count_i - step_i;
    a_d.bypass = (count_i == '0) || (step_i >= count_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) begin
      a_q <= a_d;
    end
  end

  // stage B: s*(n-k) + t*k per channel
  always_comb begin
    logic [rcfb_pkg::NumW-1:0] p_src;
    logic [rcfb_pkg::NumW-1:0] p_tgt;
    for (int ch = 0; ch < rcfb_pkg::NumChan; ch++) begin
      p_src = {{rcfb_pkg::StepW{1'b0}}, a_q.src[ch*rcfb_pkg::ChanW +: rcfb_pkg::ChanW]}
              * {{rcfb_pkg::ChanW{1'b0}}, a_q.nk};
      p_tgt = {{rcfb_pkg::StepW{1'b0}}, a_q.tgt[ch*rcfb_pkg::ChanW +: rcfb_pkg::ChanW]}
              * {{rcfb_pkg::ChanW{1'b0}}, a_q.k};
      b_d.acc[ch] = p_src + p_tgt;
    end
    b_d.divisor = a_q.n;
    b_d.tgt     = a_q.tgt;
    b_d.bypass  = a_q.bypass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || ready_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && (!b_valid_q || ready_i)) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

>>> design/rcfb_div_stage.sv
// One restoring-division stage: retires QBitsPerStg quotient bits for all
// three channels. Depends on rcfb_pkg.
`timescale 1ns / 1ps
module rcfb_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rcfb_pkg::pipe_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rcfb_pkg::pipe_t data_o
);

  logic            valid_q;
  rcfb_pkg::pipe_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // acc = {rem, low}; shift one numerator bit into rem, quotient bit into low
  always_comb begin
    logic [rcfb_pkg::StepW:0]  trial;
    logic [rcfb_pkg::NumW-1:0] acc;
    logic                      qbit;
    data_d = data_i;
    for (int ch = 0; ch < rcfb_pkg::NumChan; ch++) begin
      acc = data_i.acc[ch];
      for (int b = 0; b < rcfb_pkg::QBitsPerStg; b++) begin
        trial = {acc[rcfb_pkg::NumW-1:rcfb_pkg::ChanW], acc[rcfb_pkg::ChanW-1]};
        qbit  = (trial >= {1'b0, data_i.divisor});
        if (qbit) begin
          trial = trial - {1'b0, data_i.divisor};
        end
        acc = {trial[rcfb_pkg::StepW-1:0], acc[rcfb_pkg::ChanW-2:0], qbit};
      end
      data_d.acc[ch] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/rgb_color_fade_blend.sv
// RGB888 color fade blender, top level. Throughput one beat per clock while
// the output is not stalled, set by the fully pipelined 2-bit-per-stage
// divider (4 divide stages after 2 front stages).
// Reset (rst_ni, async active low) empties the pipeline and clears
// target_color and step_count to zero. Depends on rcfb_pkg, rcfb_mix,
// rcfb_div_stage.
`timescale 1ns / 1ps
module rgb_color_fade_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port: index 0 target_color, 1 step_count
  input  logic                         cfg_we_i,
  input  logic                         cfg_addr_i,
  input  logic [rcfb_pkg::ColorW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,  // [23:0] source_color, [39:24] step_idx
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata   // [23:0] blended_color
);

  // Config registers. The user must write them only while idle, so items in
  // flight never see a change; the block itself does not enforce this.
  logic [rcfb_pkg::ColorW-1:0] target_q;
  logic [rcfb_pkg::StepW-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        rcfb_pkg::REG_TARGET_COLOR: target_q <= cfg_wdata_i;
        rcfb_pkg::REG_STEP_COUNT:   count_q  <= cfg_wdata_i[rcfb_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // Stage chain: each stage holds its beat until the next one has room,
  // so bubbles close up and a stalled output loses nothing.
  logic            vld   [rcfb_pkg::DivStages+1];
  logic            rdy   [rcfb_pkg::DivStages+1];
  rcfb_pkg::pipe_t word  [rcfb_pkg::DivStages+1];

  // Front end: numerator = src*(n-k) + tgt*k per channel
  rcfb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .src_i   (s_axis_tdata[rcfb_pkg::ColorW-1:0]),
    .step_i  (s_axis_tdata[rcfb_pkg::ColorW +: rcfb_pkg::StepW]),
    .tgt_i   (target_q),
    .count_i (count_q),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .data_o  (word[0])
  );

  // Divider: numerator < 256*n whenever not bypassed, so the quotient
  // fits 8 bits and the partial remainder stays below n.
  for (genvar i = 0; i < rcfb_pkg::DivStages; i++) begin : g_div
    rcfb_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (word[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (word[i+1])
    );
  end

  assign rdy[rcfb_pkg::DivStages] = m_axis_tready;
  assign m_axis_tvalid            = vld[rcfb_pkg::DivStages];

  // Quotients sit in the low byte of each channel's word. Zero count or
  // step at/past count passes the target through.
  always_comb begin
    if (word[rcfb_pkg::DivStages].bypass) begin
      m_axis_tdata = word[rcfb_pkg::DivStages].tgt;
    end else begin
      for (int ch = 0; ch < rcfb_pkg::NumChan; ch++) begin
        m_axis_tdata[ch*rcfb_pkg::ChanW +: rcfb_pkg::ChanW] =
          word[rcfb_pkg::DivStages].acc[ch][rcfb_pkg::ChanW-1:0];
      end
    end
  end

endmodule

>>> dv/tb_top.sv
// Self-checking bench for rgb_color_fade_blend: per-channel cross-fade toward the
// configured target color, checked beat by beat against an in-bench predictor.
// Depends on rcfb_pkg and the rgb_color_fade_blend RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned PipeLatency = 6;     // input beat to output beat
  localparam int unsigned IdleLimit   = 2000;  // watchdog, cycles with no beat
  localparam int unsigned HoldLen     = 300;   // long receiver hold-off
  localparam int unsigned HoldAtBeat  = 150;   // output beat that triggers it
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PixPerPhase = 80;

  // one input beat; packs as {step_idx, source_color}
  typedef struct packed {
    logic [rcfb_pkg::StepW-1:0]  step;
    logic [rcfb_pkg::ColorW-1:0] src;
  } pixel_beat_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_addr_i = rcfb_pkg::REG_TARGET_COLOR;
  logic [rcfb_pkg::ColorW-1:0]   cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [39:0]                   s_axis_tdata = '0;   // [23:0] source_color, [39:24] step_idx
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [23:0]                   m_axis_tdata;        // [23:0] blended_color

  // shadow copy of the config registers
  logic [rcfb_pkg::ColorW-1:0]   fade_target = '0;
  logic [rcfb_pkg::StepW-1:0]    fade_count = '0;

  pixel_beat_t                   pixel_q[$];          // pixels waiting to be offered
  logic [rcfb_pkg::ColorW-1:0]   blend_q[$];          // expected blended colors
  int unsigned                   err_cnt = 0;
  int unsigned                   beats_out = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rgb_color_fade_blend uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Cross-fade predictor. Count zero or step at/past count gives the target as is;
  // otherwise each channel is (src*(n-k) + tgt*k) / n, truncated.
  function automatic logic [rcfb_pkg::ColorW-1:0] blend_pixel(
      input logic [rcfb_pkg::ColorW-1:0] src,
      input logic [rcfb_pkg::StepW-1:0]  k);
    logic [rcfb_pkg::ColorW-1:0] mix;
    int unsigned                 s, t, n, kk, num;
    if (fade_count == 0 || k >= fade_count) return fade_target;
    n  = 32'(fade_count);
    kk = 32'(k);
    for (int c = 0; c < rcfb_pkg::NumChan; c++) begin
      s   = 32'(src[c*rcfb_pkg::ChanW +: rcfb_pkg::ChanW]);
      t   = 32'(fade_target[c*rcfb_pkg::ChanW +: rcfb_pkg::ChanW]);
      num = s * (n - kk) + t * kk;   // stays below 2^24
      mix[c*rcfb_pkg::ChanW +: rcfb_pkg::ChanW] = 8'(num / n);
    end
    return mix;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps; the occasional
  // long burst gives stretches with no idling at all.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : pixel_driver
    pixel_beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // predict at acceptance, with the config that is live right now
      if (s_axis_tvalid && s_axis_tready)
        blend_q.push_back(blend_pixel(s_axis_tdata[23:0], s_axis_tdata[39:24]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          nxt           = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each output beat against the oldest expectation. Receiver
  // stalls switch between always-ready, coin-flip and a fixed on/off pattern;
  // once, a long hold-off lets the pipeline fill and back-pressure the input.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_tick = 0;
  int unsigned hold_left = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk_i) begin : blend_monitor
    logic [rcfb_pkg::ColorW-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (blend_q.size() == 0) begin
          $error("blended_color: beat with nothing expected, actual %06h", m_axis_tdata);
          err_cnt++;
        end else begin
          want = blend_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("blended_color: expected %06h, actual %06h", want, m_axis_tdata);
            err_cnt++;
          end
        end
      end

      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 127) stall_mode <= $urandom_range(0, 2);

      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && beats_out >= HoldAtBeat) begin
        hold_left      <= HoldLen - 1;
        long_hold_done <= 1'b1;
        m_axis_tready  <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (stall_tick % 7) < 4;
        endcase
      end
    end
  end

  // Watchdog: any beat on either side resets the count.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Register write; only called with the pipeline empty.
  task automatic cfg_write(input logic addr, input logic [rcfb_pkg::ColorW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (addr == rcfb_pkg::REG_TARGET_COLOR) fade_target = data;
    else fade_count = data[rcfb_pkg::StepW-1:0];  // upper bits dropped
  endtask

  task automatic add_pixel(input logic [rcfb_pkg::ColorW-1:0] src,
                           input logic [rcfb_pkg::StepW-1:0]  step);
    pixel_beat_t p;
    p.src  = src;
    p.step = step;
    pixel_q.push_back(p);
  endtask

  // Sender pause: nothing pending, nothing in flight, then let the pipe settle.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || blend_q.size() != 0);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  // mostly steps inside the fade, plus the edges and out-of-range ones
  function automatic logic [rcfb_pkg::StepW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return fade_count;
      3:       return 16'($urandom_range(0, 16'hFFFF));
      default: return (fade_count == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                        : 16'($urandom_range(0, fade_count - 1));
    endcase
  endfunction

  function automatic logic [rcfb_pkg::ColorW-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00};
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_seq
    logic [rcfb_pkg::StepW-1:0] cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // registers at reset: zero count, black target
    add_pixel(24'hFFFFFF, 16'h0000);
    add_pixel(24'h000000, 16'hFFFF);
    add_pixel(24'h3C7E11, 16'h0001);
    wait_drained();

    // widest fade toward white
    cfg_write(rcfb_pkg::REG_TARGET_COLOR, 24'hFFFFFF);
    cfg_write(rcfb_pkg::REG_STEP_COUNT, 24'h00FFFF);
    add_pixel(24'h000000, 16'h0000);
    add_pixel(24'hFFFFFF, 16'hFFFE);
    add_pixel(24'h000000, 16'hFFFE);
    add_pixel(24'h000000, 16'hFFFF);   // step equal to count
    add_pixel(24'h000000, 16'h0001);
    add_pixel(24'hA5C35A, 16'h8000);
    wait_drained();

    // single-step fade toward black
    cfg_write(rcfb_pkg::REG_TARGET_COLOR, 24'h000000);
    cfg_write(rcfb_pkg::REG_STEP_COUNT, 24'h000001);
    add_pixel(24'hFFFFFF, 16'h0000);
    add_pixel(24'hFFFFFF, 16'h0001);
    add_pixel(24'h123456, 16'h0000);
    wait_drained();

    // junk in the upper write bits must not reach the count (count = 3)
    cfg_write(rcfb_pkg::REG_TARGET_COLOR, 24'h80FF01);
    cfg_write(rcfb_pkg::REG_STEP_COUNT, 24'hFF0003);
    for (int k = 0; k < 5; k++) add_pixel(24'h01FF80, 16'(k));
    add_pixel(24'hFFFFFF, 16'hFFFF);
    wait_drained();

    // random phases, each with its own settings
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0) begin
        cnt = 16'hFFFF;
        cfg_write(rcfb_pkg::REG_TARGET_COLOR, 24'hFFFFFF);
      end else if (ph == 1) begin
        cnt = 16'h0000;
        cfg_write(rcfb_pkg::REG_TARGET_COLOR, 24'h000000);
      end else begin
        case ($urandom_range(0, 3))
          0:       cnt = 16'($urandom_range(1, 4));
          1:       cnt = 16'($urandom_range(5, 300));
          2:       cnt = 16'($urandom_range(301, 65535));
          default: cnt = 16'hFFFE;
        endcase
        cfg_write(rcfb_pkg::REG_TARGET_COLOR, pick_color());
      end
      cfg_write(rcfb_pkg::REG_STEP_COUNT, {8'($urandom_range(0, 255)), cnt});
      for (int i = 0; i < PixPerPhase; i++) add_pixel(pick_color(), pick_step());
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
